/* rtl/tpt_pkg.sv */
// Shared types, codes and constants for the two-level page table unit.
package tpt_pkg;

	// Default number of second-level table slots in the pool.
	localparam int unsigned DEF_TABLE_SLOTS = 16;

	// Index and field widths of the 32-bit address split.
	localparam int unsigned IDX_W     = 10;
	localparam int unsigned OFS_W     = 12;
	localparam int unsigned FRAME_W   = 32 - OFS_W;
	localparam int unsigned DIR_DEPTH = 1 << IDX_W;

	// Operation codes.
	localparam logic [1:0] FUNC_MAP       = 2'd0;
	localparam logic [1:0] FUNC_UNMAP     = 2'd1;
	localparam logic [1:0] FUNC_TRANSLATE = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_DONE        = 2'd0;
	localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
	localparam logic [1:0] ST_NO_SLOT     = 2'd2;

	// Request beat.
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] virt_addr;
		logic [31:0] phys_addr;
		logic [11:0] page_flags;
	} req_beat_t;

	// Response beat.
	typedef struct packed {
		logic [31:0] phys_out;
		logic [1:0]  status;
	} rsp_beat_t;

	// Memory port enables from the controller to the store.
	typedef struct packed {
		logic dir_rd;
		logic dir_we;
		logic tbl_rd;
		logic tbl_we;
	} mem_ctl_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_CLR,
		S_IDLE,
		S_DIR,
		S_TBL
	} tpt_state_t;

endpackage

/* rtl/tpt_store.sv */
// Directory and second-level table memories with registered read data.
module tpt_store #(
	parameter int unsigned TABLE_SLOTS = tpt_pkg::DEF_TABLE_SLOTS,
	localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
	localparam int unsigned DIR_W  = SLOT_W + 1,
	localparam int unsigned TBL_AW = SLOT_W + tpt_pkg::IDX_W
) (
	input  logic                         clk,
	input  tpt_pkg::mem_ctl_t            ctl,
	input  logic [tpt_pkg::IDX_W-1:0]    dir_rd_addr,
	input  logic [tpt_pkg::IDX_W-1:0]    dir_wr_addr,
	input  logic [DIR_W-1:0]             dir_wr_data,
	output logic [DIR_W-1:0]             dir_rd_data,
	input  logic [TBL_AW-1:0]            tbl_rd_addr,
	input  logic [TBL_AW-1:0]            tbl_wr_addr,
	input  logic [31:0]                  tbl_wr_data,
	output logic [31:0]                  tbl_rd_data
);
	import tpt_pkg::*;

	localparam int unsigned TBL_DEPTH = TABLE_SLOTS * DIR_DEPTH;

	logic [DIR_W-1:0] dir_mem [DIR_DEPTH];
	logic [31:0]      tbl_mem [TBL_DEPTH];
	logic [DIR_W-1:0] dir_data_q;
	logic [31:0]      tbl_data_q;

	// Directory memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.dir_we) begin
			dir_mem[dir_wr_addr] <= dir_wr_data;
		end
		if (ctl.dir_rd) begin
			dir_data_q <= dir_mem[dir_rd_addr];
		end
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.tbl_we) begin
			tbl_mem[tbl_wr_addr] <= tbl_wr_data;
		end
		if (ctl.tbl_rd) begin
			tbl_data_q <= tbl_mem[tbl_rd_addr];
		end
	end

	assign dir_rd_data = dir_data_q;
	assign tbl_rd_data = tbl_data_q;

endmodule

/* rtl/two_level_page_table_unit.sv */
// Top level of the two-level page table unit: request control and response register.
//
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid, req_ready  | func, virt_addr, phys_addr, page_flags
// rsp     | out       | rsp_valid, rsp_ready  | phys_out, status
//
// Every request starts with a directory memory read; map and unmap then do the dependent
// table memory write in the directory step, and a translate with a present entry adds a
// table step that reads the table memory for the response.
// After reset a clearing pass over all TABLE_SLOTS * 1024 table entries (16384 by default)
// zeroes both memories; req_ready stays low until it ends.
// One new request is taken while a finished response waits in the output register.
// While the output register is full and rsp_ready is low, a request holds in its last step without touching memory.
module two_level_page_table_unit #(
	parameter int unsigned TABLE_SLOTS = tpt_pkg::DEF_TABLE_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  tpt_pkg::req_beat_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output tpt_pkg::rsp_beat_t rsp
);
	import tpt_pkg::*;

	localparam int unsigned SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int unsigned DIR_W     = SLOT_W + 1;
	localparam int unsigned TBL_AW    = SLOT_W + IDX_W;
	localparam int unsigned CNT_W     = $clog2(TABLE_SLOTS + 1);
	localparam int unsigned TBL_DEPTH = TABLE_SLOTS * DIR_DEPTH;

	tpt_state_t        state_q, state_d;
	logic [TBL_AW-1:0] clr_q;
	logic [CNT_W-1:0]  nfs_q;
	req_beat_t         item_q;
	logic              rsp_valid_q;
	rsp_beat_t         rsp_q;

	mem_ctl_t          ctl;
	logic [IDX_W-1:0]  dir_wr_addr;
	logic [DIR_W-1:0]  dir_wr_data;
	logic [DIR_W-1:0]  dir_rd_data;
	logic [TBL_AW-1:0] tbl_addr;
	logic [TBL_AW-1:0] tbl_wr_addr;
	logic [31:0]       tbl_wr_data;
	logic [31:0]       tbl_rd_data;

	logic              rsp_load;
	rsp_beat_t         rsp_d;
	logic              alloc_take;

	logic              out_free;
	logic              present;
	logic              pool_empty;
	logic [SLOT_W-1:0] use_slot;
	logic              clr_last;
	logic              trans_hit;

	// Memories.
	tpt_store #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_store (
		.clk        (clk),
		.ctl        (ctl),
		.dir_rd_addr(req.virt_addr[31:22]),
		.dir_wr_addr(dir_wr_addr),
		.dir_wr_data(dir_wr_data),
		.dir_rd_data(dir_rd_data),
		.tbl_rd_addr(tbl_addr),
		.tbl_wr_addr(tbl_wr_addr),
		.tbl_wr_data(tbl_wr_data),
		.tbl_rd_data(tbl_rd_data)
	);

	// Decoded directory entry and slot choice for the current request.
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign present    = dir_rd_data[SLOT_W];
	assign pool_empty = (nfs_q >= CNT_W'(TABLE_SLOTS));
	assign use_slot   = present ? dir_rd_data[SLOT_W-1:0] : nfs_q[SLOT_W-1:0];
	assign tbl_addr   = {use_slot, item_q.virt_addr[21:12]};
	assign clr_last   = (clr_q == TBL_AW'(TBL_DEPTH - 1));
	assign trans_hit  = (item_q.func == FUNC_TRANSLATE) && present;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				if (clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DIR;
				end
			end
			S_DIR: begin
				if (trans_hit) begin
					state_d = S_TBL;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_TBL: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory control and response generation.
	always_comb begin
		ctl         = '0;
		req_ready   = 1'b0;
		dir_wr_addr = item_q.virt_addr[31:22];
		dir_wr_data = {1'b1, nfs_q[SLOT_W-1:0]};
		tbl_wr_addr = tbl_addr;
		tbl_wr_data = 32'd0;
		rsp_load    = 1'b0;
		rsp_d       = '0;
		alloc_take  = 1'b0;
		case (state_q)
			S_CLR: begin
				ctl.dir_we  = 1'b1;
				ctl.tbl_we  = 1'b1;
				dir_wr_addr = clr_q[IDX_W-1:0];
				dir_wr_data = '0;
				tbl_wr_addr = clr_q;
			end
			S_IDLE: begin
				req_ready  = 1'b1;
				ctl.dir_rd = req_valid;
			end
			S_DIR: begin
				if (trans_hit) begin
					ctl.tbl_rd = 1'b1;
				end else if (out_free) begin
					rsp_load = 1'b1;
					case (item_q.func)
						FUNC_MAP: begin
							if (!present && pool_empty) begin
								rsp_d.status = ST_NO_SLOT;
							end else begin
								ctl.dir_we  = !present;
								alloc_take  = !present;
								ctl.tbl_we  = 1'b1;
								tbl_wr_data = {item_q.phys_addr[31:OFS_W], item_q.page_flags};
							end
						end
						FUNC_UNMAP: begin
							if (present) begin
								ctl.tbl_we = 1'b1;
							end else begin
								rsp_d.status = ST_NOT_PRESENT;
							end
						end
						FUNC_TRANSLATE: begin
							rsp_d.status = ST_NOT_PRESENT;
						end
						default: rsp_d.status = ST_DONE;
					endcase
				end
			end
			S_TBL: begin
				if (out_free) begin
					rsp_load       = 1'b1;
					rsp_d.phys_out = {tbl_rd_data[31:OFS_W], item_q.virt_addr[OFS_W-1:0]};
					rsp_d.status   = ST_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			nfs_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + TBL_AW'(1);
			end
			if (alloc_take) begin
				nfs_q <= nfs_q + CNT_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// The slot pool count never runs past the pool size.
	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nfs_q <= CNT_W'(TABLE_SLOTS))
		else $error("slot count exceeds pool size");

	// A new response never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || rsp_ready))
		else $error("response register overwritten");

	// An accepted request always moves on to the directory step.
	a_accept_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == S_DIR))
		else $error("accepted request did not reach directory step");

	// Taking a slot advances the pool count by exactly one.
	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_take |=> (nfs_q == $past(nfs_q) + CNT_W'(1)))
		else $error("slot allocation did not advance the pool count");

	// Table memory writes only happen during the clearing pass or the directory step.
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.tbl_we |-> (state_q == S_CLR || state_q == S_DIR))
		else $error("table write outside its step");
`endif

endmodule
